>>> rtl/tsosc_pkg.sv
// Shared constants for the transport stream output schedule checker.
// No dependencies; used by ts_output_schedule_checker_unit.
package tsosc_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 48;

  localparam int unsigned CHANNEL_W = 6;
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned DELAY_W   = 19;
  localparam int unsigned FLAGS_W   = 3;
  localparam int unsigned PID_W     = 13;
  localparam int unsigned CC_W      = 4;
  localparam int unsigned OFFB_W    = 32;
  localparam int unsigned OFFE_W    = 10;
  localparam int unsigned AF_W      = 3;
  localparam int unsigned PCR_W     = 42;

  // restamp flag bit positions
  localparam int unsigned FLAG_PID = 0;
  localparam int unsigned FLAG_CC  = 1;
  localparam int unsigned FLAG_PCR = 2;

  // adaptation field status meaning "PCR present"
  localparam logic [AF_W-1:0] AF_PCR_PRESENT = 3'b111;

  // PCR base LSB is worth half a 45 kHz tick: 300 steps of 27 MHz
  localparam logic [OFFE_W-1:0] HALF_EXT = 10'd300;

  // PCR field slicing: local time uses base bits 20..1, i.e. pcr bits 29..10
  localparam int unsigned PCR_T_LO   = 10;
  localparam int unsigned PCR_HALF   = 9;
  localparam int unsigned PCR_EXT_W  = 9;

endpackage

>>> rtl/ts_output_schedule_checker_unit.sv
// Output schedule checker top level: two-stage checker with per-channel state memory.
// Depends on tsosc_pkg.
//
// Checks each output transport packet word against the command that produced it and
// returns one result word per input word, in order, one per clock while out_stall is low.
// The channel's state is read into a register at the edge that accepts the word; the
// word is evaluated in the following cycle and written back as the result register
// loads, so out_valid rises at the edge after acceptance when out_stall is low. A word
// accepted at the edge where the previous word writes back the same channel takes that
// update from a bypass register, so back-to-back words on one channel see each other's
// updates. Flags: PID or CC
// differs from the commanded value while its restamp bit is set; output time lies
// behind the channel's last output time (signed 20-bit wrapping difference); PCR
// restamp requested but no PCR in the packet; output time earlier than the local PCR
// (output PCR less the time base offset, low 20 bits). The channel peak delay output
// is the largest non-negative delay seen on the channel. Channels at or above
// CHANNEL_COUNT touch no state and report no backward time and a zero maximum. After
// reset all channel state reads as zero (per-channel valid bits, no clearing pass
// needed). in_stall rises only while the result register is full and held by out_stall.
module ts_output_schedule_checker_unit #(
  parameter int unsigned CHANNEL_COUNT = tsosc_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tsosc_pkg::CHANNEL_W-1:0]   in_channel,
  input  logic [tsosc_pkg::TIME_W-1:0]      in_sched_time,
  input  logic [tsosc_pkg::FLAGS_W-1:0]     in_restamp_flags,
  input  logic [tsosc_pkg::PID_W-1:0]       in_expected_pid,
  input  logic [tsosc_pkg::CC_W-1:0]        in_expected_cc,
  input  logic [tsosc_pkg::OFFB_W-1:0]      in_offset_base,
  input  logic [tsosc_pkg::OFFE_W-1:0]      in_offset_ext,
  input  logic [tsosc_pkg::PID_W-1:0]       in_stream_pid,
  input  logic [tsosc_pkg::CC_W-1:0]        in_stream_cc,
  input  logic [tsosc_pkg::AF_W-1:0]        in_af_status,
  input  logic [tsosc_pkg::PCR_W-1:0]       in_pcr_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_pid_mismatch,
  output logic                              out_cc_mismatch,
  output logic                              out_time_backward,
  output logic                              out_pcr_missing,
  output logic                              out_scheduled_early,
  output logic [tsosc_pkg::DELAY_W-1:0]     out_channel_peak_delay
);

  localparam int unsigned IDX_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned TIME_W  = tsosc_pkg::TIME_W;
  localparam int unsigned DELAY_W = tsosc_pkg::DELAY_W;
  localparam int unsigned ENT_W   = TIME_W + DELAY_W;
  localparam logic [tsosc_pkg::CHANNEL_W:0] CH_LIMIT = (tsosc_pkg::CHANNEL_W + 1)'(CHANNEL_COUNT);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_v_r;
  logic out_valid_r;
  logic s1_go;
  logic in_acc;

  // stage 1 moves on whenever the result register is empty or being drained
  assign s1_go    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Input side: cheap compares and the local PCR time, ahead of the stage register
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]                in_idx;
  logic                            in_inrange;
  logic [tsosc_pkg::OFFE_W-1:0]    in_ext;
  logic                            in_borrow;
  logic [TIME_W-1:0]               in_local;

  assign in_idx     = in_channel[IDX_W-1:0];
  assign in_inrange = {1'b0, in_channel} < CH_LIMIT;

  // PCR extension in 27 MHz steps, base LSB counting as half a tick (0..811)
  assign in_ext = (in_pcr_value[tsosc_pkg::PCR_HALF] ? tsosc_pkg::HALF_EXT
                                                     : {tsosc_pkg::OFFE_W{1'b0}})
                + {1'b0, in_pcr_value[tsosc_pkg::PCR_EXT_W-1:0]};
  assign in_borrow = in_ext < in_offset_ext;
  assign in_local  = in_pcr_value[tsosc_pkg::PCR_T_LO +: TIME_W]
                   - in_offset_base[TIME_W-1:0]
                   - {{(TIME_W-1){1'b0}}, in_borrow};

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_inrange_r;
  logic [TIME_W-1:0] s1_time_r;
  logic [TIME_W-1:0] s1_local_r;
  logic              s1_pid_bad_r;
  logic              s1_cc_bad_r;
  logic              s1_pcr_chk_r;
  logic              s1_pcr_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r     <= in_idx;
      s1_inrange_r <= in_inrange;
      s1_time_r    <= in_sched_time;
      s1_local_r   <= in_local;
      s1_pid_bad_r <= in_restamp_flags[tsosc_pkg::FLAG_PID] &&
                      (in_stream_pid != in_expected_pid);
      s1_cc_bad_r  <= in_restamp_flags[tsosc_pkg::FLAG_CC] &&
                      (in_stream_cc != in_expected_cc);
      s1_pcr_chk_r <= in_restamp_flags[tsosc_pkg::FLAG_PCR];
      s1_pcr_ok_r  <= in_af_status == tsosc_pkg::AF_PCR_PRESENT;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel state: {last output time, largest delay}, registered read
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0]         mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] vld_r;
  logic [ENT_W-1:0]         rd_r;
  logic                     rd_vld_r;
  logic                     byp_hit_r;
  logic [ENT_W-1:0]         byp_r;
  logic                     wr_en;
  logic [ENT_W-1:0]         wr_data;

  assign wr_en = s1_go && s1_inrange_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx_r] <= wr_data;
    end
    if (in_acc) begin
      rd_r     <= mem[in_idx];
      rd_vld_r <= vld_r[in_idx];
      byp_r    <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[s1_idx_r] <= 1'b1;
      end
      if (in_acc) begin
        // write landing at the same edge as the read: memory data is stale
        byp_hit_r <= wr_en && (s1_idx_r == in_idx);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 evaluation
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0]   prev_ent;
  logic [TIME_W-1:0]  prev_time;
  logic [DELAY_W-1:0] prev_delay;
  logic [TIME_W-1:0]  back_diff;
  logic [TIME_W-1:0]  delay;
  logic               back;
  logic               early;
  logic               missing;
  logic [DELAY_W-1:0] new_delay;

  always_comb begin
    if (byp_hit_r) begin
      prev_ent = byp_r;
    end else if (rd_vld_r) begin
      prev_ent = rd_r;
    end else begin
      prev_ent = '0;
    end
  end

  assign prev_time  = prev_ent[ENT_W-1:DELAY_W];
  assign prev_delay = prev_ent[DELAY_W-1:0];

  assign back_diff = s1_time_r - prev_time;
  assign back      = s1_inrange_r && back_diff[TIME_W-1];

  assign delay   = s1_time_r - s1_local_r;
  assign missing = s1_pcr_chk_r && !s1_pcr_ok_r;
  assign early   = s1_pcr_chk_r && s1_pcr_ok_r && delay[TIME_W-1];

  always_comb begin
    new_delay = prev_delay;
    if (s1_pcr_chk_r && s1_pcr_ok_r && !delay[TIME_W-1] &&
        (delay[DELAY_W-1:0] > prev_delay)) begin
      new_delay = delay[DELAY_W-1:0];
    end
  end

  assign wr_data = {s1_time_r, new_delay};

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic               pid_bad_r;
  logic               cc_bad_r;
  logic               back_r;
  logic               missing_r;
  logic               early_r;
  logic [DELAY_W-1:0] maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pid_bad_r <= s1_pid_bad_r;
      cc_bad_r  <= s1_cc_bad_r;
      back_r    <= back;
      missing_r <= missing;
      early_r   <= early;
      maxd_r    <= s1_inrange_r ? new_delay : {DELAY_W{1'b0}};
    end
  end

  assign out_valid              = out_valid_r;
  assign out_pid_mismatch       = pid_bad_r;
  assign out_cc_mismatch        = cc_bad_r;
  assign out_time_backward      = back_r;
  assign out_pcr_missing        = missing_r;
  assign out_scheduled_early    = early_r;
  assign out_channel_peak_delay = maxd_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_byp_on_same_ch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wr_en && (s1_idx_r == in_idx)) |=> byp_hit_r)
    else $error("same-channel write back not taken from the bypass");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline can move");

  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (new_delay >= prev_delay))
    else $error("channel maximum delay decreased");

  a_early_excl_missing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(missing_r && early_r))
    else $error("PCR missing and early flagged together");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_inrange_r) |=> (maxd_r == '0 && !back_r))
    else $error("out-of-range channel reported state");

endmodule
